>>> design/fcpc_pkg.sv
// Shared constants and helpers for the float / link word codec.
// No dependencies.
package fcpc_pkg;
  localparam logic [31:0] LW_NAN     = 32'h7F00_0000;
  localparam logic [31:0] LW_POS_INF = 32'h7FFF_FF7F;
  localparam logic [31:0] LW_NEG_INF = 32'h7F00_0080;
  localparam logic [31:0] F_QNAN     = 32'h7FC0_0000;
  localparam logic        CMD_ENCODE = 1'b0;
  localparam logic        CMD_DECODE = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [31:0] word;
  } item_t;

  // position of highest set bit in a 23-bit value (0 when zero)
  function automatic logic [4:0] msb_pos(input logic [22:0] v);
    logic [4:0] p;
    p = 5'd0;
    for (int i = 0; i < 23; i++) begin
      if (v[i]) p = 5'(i);
    end
    return p;
  endfunction
endpackage

>>> design/fcpc_encode.sv
// Encode path: IEEE single bits to link word, combinational.
// Depends on fcpc_pkg.
module fcpc_encode (
  input  logic [31:0] f,
  output logic [31:0] w
);
  logic        sgn;
  logic [7:0]  bexp;
  logic [22:0] frac;
  logic [4:0]  p;
  logic [22:0] smag;
  logic [7:0]  se;
  logic [7:0]  ne;

  assign sgn  = f[31];
  assign bexp = f[30:23];
  assign frac = f[22:0];
  assign p    = fcpc_pkg::msb_pos(frac);
  assign smag = frac << (5'd22 - p);
  assign se   = 8'(9'd256 + 9'(p) - 9'd148);
  assign ne   = bexp - 8'd126;

  always_comb begin
    if (bexp == 8'hFF) begin
      if (frac != 23'd0) w = fcpc_pkg::LW_NAN;
      else w = sgn ? fcpc_pkg::LW_NEG_INF : fcpc_pkg::LW_POS_INF;
    end else if (bexp == 8'd0) begin
      if (frac == 23'd0) w = {8'd0, sgn, 23'd0};
      else if (p < 5'd22) w = 32'd0;
      else w = {se, sgn, smag};
    end else if (bexp inside {8'hFD, 8'hFE}) begin
      w = sgn ? fcpc_pkg::LW_NEG_INF : fcpc_pkg::LW_POS_INF;
    end else begin
      w = {ne, sgn, 1'b1, frac[22:1]};
    end
  end
endmodule

>>> design/fcpc_decode.sv
// Decode path: link word to IEEE single bits with nearest-even rounding.
// Depends on fcpc_pkg.
module fcpc_decode (
  input  logic [31:0] w,
  output logic [31:0] f
);
  logic              sgn;
  logic [22:0]       mag;
  logic signed [8:0] e;
  logic [4:0]        p;
  logic signed [9:0] be;
  logic [22:0]       nfrac;
  logic signed [9:0] k;
  logic [4:0]        s;
  logic [22:0]       q0;
  logic [22:0]       rem;
  logic [22:0]       half;
  logic [22:0]       q;

  assign sgn   = w[23];
  assign mag   = w[22:0];
  assign e     = 9'(signed'(w[31:24]));
  assign p     = fcpc_pkg::msb_pos(mag);
  assign be    = 10'(signed'({1'b0, p})) + 10'(e) + 10'sd104;
  assign nfrac = mag << (5'd23 - p);
  assign k     = 10'(e) + 10'sd126;
  assign s     = (k < -10'sd24) ? 5'd24 : 5'(-k);
  assign q0    = mag >> s;
  assign rem   = mag & ((23'd1 << s) - 23'd1);
  assign half  = 23'd1 << (s - 5'd1);

  always_comb begin
    if (k >= 10'sd0) q = mag << k[4:0];
    else if (rem > half || (rem == half && q0[0])) q = q0 + 23'd1;
    else q = q0;
  end

  always_comb begin
    if (w == fcpc_pkg::LW_NAN) f = fcpc_pkg::F_QNAN;
    else if (w == fcpc_pkg::LW_NEG_INF) f = 32'hFF80_0000;
    else if (w == fcpc_pkg::LW_POS_INF) f = 32'h7F80_0000;
    else if (mag == 23'd0) f = {sgn, 31'd0};
    else if (be >= 10'sd1) f = {sgn, be[7:0], nfrac};
    else f = {sgn, 8'd0, q};
  end
endmodule

>>> design/float_custom_pack_codec_unit.sv
// Top level of the float / link word codec: input register, converter, skid output.
// Depends on fcpc_pkg, fcpc_encode, fcpc_decode.
//
// channel | dir | tdata                | tuser
// in_     | in  | [31:0] word_in       | [0] command
// out_    | out | [31:0] word_out      | -
//
// Each beat passes the input register, then the output register; one beat per cycle while
// the skid stage is empty. The converter between the two registers is combinational.
// rst_n clears the valid flags; data registers are not reset.
// A stalled output holds its beat while one more is parked in the skid stage.
module float_custom_pack_codec_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,  // word_in
  input  logic        in_tuser,  // command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata  // word_out
);
  fcpc_pkg::item_t it_r;
  logic            iv_r;
  logic [31:0]     enc_w, dec_w, res;
  logic [31:0]     o_r, sk_r;
  logic            ov_r, sv_r;
  logic            adv;

  fcpc_encode u_enc (.f(it_r.word), .w(enc_w));
  fcpc_decode u_dec (.w(it_r.word), .f(dec_w));

  assign res       = (it_r.cmd == fcpc_pkg::CMD_DECODE) ? dec_w : enc_w;
  assign in_tready = !sv_r;
  assign adv       = iv_r && !sv_r;
  assign out_tvalid = ov_r;
  assign out_tdata  = o_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r <= 1'b0;
      ov_r <= 1'b0;
      sv_r <= 1'b0;
    end else begin
      if (in_tready) begin
        iv_r <= in_tvalid;
        it_r <= '{cmd: in_tuser, word: in_tdata};
      end
      if (!ov_r || out_tready) begin
        if (sv_r) begin
          o_r  <= sk_r;
          ov_r <= 1'b1;
          sv_r <= 1'b0;
        end else begin
          o_r  <= res;
          ov_r <= adv;
        end
      end else if (adv) begin
        sk_r <= res;
        sv_r <= 1'b1;
      end
    end
  end
endmodule

>>> tb/tb.sv
// Self-checking testbench for float_custom_pack_codec_unit: encode and decode beats
// are predicted in SV and compared in order. Depends on fcpc_pkg and the codec top.
module tb;
  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;

  fcpc_pkg::item_t pending_q[$];
  logic [31:0] expected_words[$];
  int          errors;
  int          cycle_count;
  int          send_idle_pct;
  int          recv_idle_pct;
  bit          send_hold;

  float_custom_pack_codec_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  function automatic int top_bit(input logic [31:0] v);
    int n;
    n = -1;
    for (int i = 0; i < 32; i++) if (v[i]) n = i;
    return n;
  endfunction

  function automatic logic [31:0] pack_link(input logic [22:0] mag, input logic sgn,
                                            input int e);
    logic [7:0] eb;
    eb = 8'(e);
    return {eb, sgn, mag};
  endfunction

  function automatic logic [31:0] float_to_link(input logic [31:0] f);
    logic        sgn;
    logic [7:0]  bexp;
    logic [22:0] frac;
    int          e;
    int          bl;
    logic [31:0] tmp;
    sgn  = f[31];
    bexp = f[30:23];
    frac = f[22:0];
    if (bexp == 8'hFF) begin
      if (frac != 0) return fcpc_pkg::LW_NAN;
      return sgn ? fcpc_pkg::LW_NEG_INF : fcpc_pkg::LW_POS_INF;
    end
    if (bexp == 8'h00) begin
      if (frac == 0) return pack_link(23'd0, sgn, 0);
      bl = top_bit({9'd0, frac}) + 1;
      e = bl - 149;
      if (e < -126) return 32'd0;
      tmp = {9'd0, frac} << (23 - bl);
      return pack_link(tmp[22:0], sgn, e);
    end
    e = int'(bexp) - 126;
    if (e > 126) return sgn ? fcpc_pkg::LW_NEG_INF : fcpc_pkg::LW_POS_INF;
    tmp = {9'd1, frac} >> 1;
    return pack_link(tmp[22:0], sgn, e);
  endfunction

  function automatic logic [31:0] link_to_float(input logic [31:0] w);
    logic        sgn;
    logic [31:0] mag;
    logic [31:0] q;
    logic [31:0] rem;
    logic [31:0] half;
    logic [31:0] fr;
    int          e;
    int          p;
    int          k;
    int          s;
    if (w == fcpc_pkg::LW_NAN) return fcpc_pkg::F_QNAN;
    if (w == fcpc_pkg::LW_NEG_INF) return 32'hFF80_0000;
    if (w == fcpc_pkg::LW_POS_INF) return 32'h7F80_0000;
    sgn = w[23];
    mag = {9'd0, w[22:0]};
    e = int'($signed(w[31:24]));
    if (mag == 0) return {sgn, 31'd0};
    p = top_bit(mag);
    if (p + e + 104 >= 1) begin
      fr = (mag << (23 - p)) & 32'h7F_FFFF;
      return {sgn, 8'(p + e + 104), fr[22:0]};
    end
    k = e + 126;
    if (k >= 0) begin
      q = mag << k;
    end else begin
      s = -k;
      if (s > 24) s = 24;
      q = mag >> s;
      rem = mag & ((32'd1 << s) - 1);
      half = 32'd1 << (s - 1);
      if (rem > half || (rem == half && q[0])) q = q + 1;
    end
    return {sgn, 31'd0} | q;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("tb: mismatch %s got %08h want %08h at cycle %0d", what, got, want,
             cycle_count);
    errors++;
  endtask

  task automatic add_beat(input logic cmd, input logic [31:0] w);
    fcpc_pkg::item_t it;
    it.cmd  = cmd;
    it.word = w;
    pending_q.push_back(it);
  endtask

  function automatic logic [31:0] random_float();
    logic [31:0] f;
    f = $urandom;
    case ($urandom_range(0, 5))
      0: f[30:23] = 8'h00;
      1: f[30:23] = 8'hFF;
      2: f[30:23] = 8'(253 + $urandom_range(0, 1));
      3: f[30:23] = 8'($urandom_range(0, 3));
      default: ;
    endcase
    return f;
  endfunction

  function automatic logic [31:0] random_link();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(0, 7))
      0: w[31:24] = 8'($signed($urandom_range(0, 40)) - 150 + 256);
      1: w[31:24] = 8'($urandom_range(120, 127));
      2: w[22:0] = 23'($urandom_range(0, 3));
      3: w = fcpc_pkg::LW_NAN;
      4: w = $urandom_range(0, 1) ? fcpc_pkg::LW_POS_INF : fcpc_pkg::LW_NEG_INF;
      default: ;
    endcase
    return w;
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (pending_q.size() != 0 && !send_hold && $urandom_range(0, 99) >= send_idle_pct)
      begin
        in_tvalid <= 1'b1;
        in_tdata  <= pending_q[0].word;
        in_tuser  <= pending_q[0].cmd;
        expected_words.push_back(pending_q[0].cmd == fcpc_pkg::CMD_DECODE ?
                                 link_to_float(pending_q[0].word) :
                                 float_to_link(pending_q[0].word));
        void'(pending_q.pop_front());
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected beat", out_tdata, 32'd0);
        end else begin
          if (out_tdata !== expected_words[0])
            report_mismatch("word_out", out_tdata, expected_words[0]);
          void'(expected_words.pop_front());
        end
      end
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (cycle_count > 200000) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  initial begin
    logic [31:0] dir_f[$];
    logic [31:0] dir_l[$];
    errors = 0;
    cycle_count = 0;
    send_idle_pct = 21;
    recv_idle_pct = 74;
    send_hold = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = 32'd0;
    in_tuser = 1'b0;
    out_tready = 1'b0;
    dir_f = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
              32'h7FC0_0000, 32'hFF80_0001, 32'h7F7F_FFFF, 32'hFF00_0000,
              32'h0000_0001, 32'h0040_0000, 32'h807F_FFFF, 32'h3F80_0000,
              32'hFFFF_FFFF};
    dir_l = '{fcpc_pkg::LW_NAN, fcpc_pkg::LW_POS_INF, fcpc_pkg::LW_NEG_INF,
              32'h0080_0000, 32'h0000_0000,
              32'h7F7F_FFFF, 32'h80FF_FFFF, 32'h8000_0001, 32'h9C40_0000,
              32'h9C60_0000, 32'h9D40_0000, 32'hFFFF_FFFF};
    foreach (dir_f[i]) add_beat(fcpc_pkg::CMD_ENCODE, dir_f[i]);
    foreach (dir_l[i]) add_beat(fcpc_pkg::CMD_DECODE, dir_l[i]);
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    for (int phase = 0; phase < 3; phase++) begin
      for (int n = 0; n < 384; n++) begin
        if ($urandom_range(0, 1)) add_beat(fcpc_pkg::CMD_DECODE, random_link());
        else add_beat(fcpc_pkg::CMD_ENCODE, random_float());
      end
      while (pending_q.size() != 0) @(posedge clk);
      send_hold = 1'b1;
      while (expected_words.size() != 0) @(posedge clk);
      send_hold = 1'b0;
      send_idle_pct = (phase == 0) ? 74 : 0;
      recv_idle_pct = (phase == 0) ? 21 : 0;
    end
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end
endmodule

>>> filelist.f
design/fcpc_pkg.sv
design/fcpc_encode.sv
design/fcpc_decode.sv
design/float_custom_pack_codec_unit.sv
tb/tb.sv
